// File: design/tcfc_pkg.sv
// ----------------------------------------------------------------------------
// tcfc_pkg
// Shared constants and types of the trace context frame capture unit.
// ----------------------------------------------------------------------------
package tcfc_pkg;

	localparam int RING_DEPTH_DEF = 8192;
	localparam int PATH_BYTES_DEF = 101;

	localparam int HDR_BYTES   = 4;
	localparam int TRACE_FIRST = 9;
	localparam int PATH_FIRST  = 17;

	localparam logic [7:0] CTX_FRAME_TYPE_RST = 8'h0A;

	localparam logic [31:0] MAGIC_HTTP = 32'h4854_5450;
	localparam logic [31:0] MAGIC_GET  = 32'h4745_5420;
	localparam logic [31:0] MAGIC_POST = 32'h504F_5354;
	localparam logic [31:0] MAGIC_PRI  = 32'h5052_4920;

	localparam logic [1:0] KIND_STAGED = 2'd0;
	localparam logic [1:0] KIND_COMMIT = 2'd1;
	localparam logic [1:0] KIND_EVICT  = 2'd2;

	// All results caused by one input item: a staged byte, then optionally
	// a commit and an eviction.
	typedef struct packed {
		logic [6:0]  idx;
		logic [7:0]  val;
		logic        commit;
		logic        evict;
		logic [63:0] commit_key;
		logic [63:0] evict_key;
	} tcfc_bundle_t;

	function automatic logic is_magic(input logic [31:0] w);
		is_magic = (w == MAGIC_HTTP) || (w == MAGIC_GET) ||
			(w == MAGIC_POST) || (w == MAGIC_PRI);
	endfunction

endpackage

// File: design/tcfc_parse.sv
// ----------------------------------------------------------------------------
// tcfc_parse
// Byte parser: header check, trace id capture, path staging and the
// eviction ring. Produces one result bundle per emitting item.
// ----------------------------------------------------------------------------
module tcfc_parse #(
	parameter int RING_DEPTH = tcfc_pkg::RING_DEPTH_DEF,
	parameter int PATH_BYTES = tcfc_pkg::PATH_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            ctx_frame_type,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            data_byte,
	input  logic                  end_of_message,
	input  logic                  q_full,
	output logic                  push,
	output tcfc_pkg::tcfc_bundle_t push_bundle
);
	import tcfc_pkg::*;

	localparam int PATH_LAST = PATH_FIRST + PATH_BYTES - 1;
	localparam int POS_LIMIT = PATH_LAST + 1;
	localparam int POS_W     = $clog2(POS_LIMIT + 1);
	localparam int PTR_W     = $clog2(RING_DEPTH);

	logic [POS_W-1:0] pos_q;
	logic [31:0]      hdr_q;
	logic             acc_q;
	logic [63:0]      trace_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [63:0]      ring_mem [RING_DEPTH];
	logic [63:0]      head_data_q;

	logic             accept;
	logic             emit;
	logic             at_last;
	logic [31:0]      hdr_next;
	logic [PTR_W-1:0] tail_inc;
	logic [PTR_W-1:0] head_inc;
	logic             commit;
	logic             evict;

	// Whether the next item emits depends on state only, so ready does not
	// look at the payload.
	assign emit    = acc_q && (pos_q >= POS_W'(PATH_FIRST)) && (pos_q <= POS_W'(PATH_LAST));
	assign at_last = pos_q == POS_W'(PATH_LAST);
	assign in_ready = !emit || !q_full;
	assign accept   = in_valid && in_ready;
	assign hdr_next = {hdr_q[23:0], data_byte};

	assign tail_inc = (tail_q == PTR_W'(RING_DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign head_inc = (head_q == PTR_W'(RING_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign commit   = accept && emit && at_last;
	// Ring full after this write: the oldest id goes out
	assign evict    = commit && (tail_inc == head_q);

	assign push = accept && emit;
	always_comb begin
		push_bundle            = '0;
		push_bundle.idx        = 7'(pos_q - POS_W'(PATH_FIRST));
		push_bundle.val        = data_byte;
		push_bundle.commit     = at_last;
		push_bundle.evict      = at_last && (tail_inc == head_q);
		push_bundle.commit_key = trace_q;
		push_bundle.evict_key  = head_data_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			hdr_q   <= '0;
			acc_q   <= 1'b0;
			trace_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
		end else begin
			if (commit) begin
				tail_q <= tail_inc;
			end
			if (evict) begin
				head_q <= head_inc;
			end
			if (accept) begin
				if (end_of_message) begin
					pos_q   <= '0;
					hdr_q   <= '0;
					acc_q   <= 1'b0;
					trace_q <= '0;
				end else begin
					if (pos_q < POS_W'(HDR_BYTES)) begin
						hdr_q <= hdr_next;
						if (pos_q == POS_W'(HDR_BYTES - 1)) begin
							acc_q <= !is_magic(hdr_next) && (data_byte == ctx_frame_type);
						end
					end else if (pos_q >= POS_W'(TRACE_FIRST) && pos_q < POS_W'(PATH_FIRST)) begin
						trace_q <= {trace_q[55:0], data_byte};
					end
					if (pos_q < POS_W'(POS_LIMIT)) begin
						pos_q <= pos_q + 1'b1;
					end
				end
			end
		end
	end

	// Head entry is read every cycle; commits are far apart, so the
	// registered copy is always current when an eviction needs it.
	always_ff @(posedge clk) begin
		if (commit) begin
			ring_mem[tail_q] <= trace_q;
		end
		head_data_q <= ring_mem[head_q];
	end

	a_evict_needs_commit: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_bundle.evict |-> push_bundle.commit)
		else $error("eviction without commit");

	a_ring_full_after_evict: assert property (@(posedge clk) disable iff (!arst_n)
		evict |=> head_q == tail_inc)
		else $error("head does not lead tail by one after eviction");

	a_accept_after_header: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q |-> pos_q >= POS_W'(HDR_BYTES))
		else $error("frame accepted before header complete");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("push into full result queue");

endmodule

// File: design/tcfc_outq.sv
// ----------------------------------------------------------------------------
// tcfc_outq
// Two-slot queue of result bundles, serialized one result per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module tcfc_outq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  tcfc_pkg::tcfc_bundle_t push_bundle,
	output logic                  q_full,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            kind,
	output logic [6:0]            path_index,
	output logic [7:0]            path_value,
	output logic [63:0]           trace_key,
	output logic                  last_of_run
);
	import tcfc_pkg::*;

	localparam logic [1:0] SEL_STAGED = 2'd0;
	localparam logic [1:0] SEL_COMMIT = 2'd1;
	localparam logic [1:0] SEL_EVICT  = 2'd2;

	tcfc_bundle_t slot_q [2];
	logic         wp_q;
	logic         rp_q;
	logic [1:0]   cnt_q;
	logic [1:0]   sel_q;

	tcfc_bundle_t cur;
	logic         adv;
	logic         pop;

	assign cur       = slot_q[rp_q];
	assign q_full    = cnt_q == 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign adv       = out_valid && out_ready;
	assign pop       = adv && last_of_run;

	always_comb begin
		kind        = KIND_STAGED;
		path_index  = '0;
		path_value  = '0;
		trace_key   = '0;
		last_of_run = 1'b1;
		case (sel_q)
			SEL_STAGED: begin
				path_index  = cur.idx;
				path_value  = cur.val;
				last_of_run = !cur.commit;
			end
			SEL_COMMIT: begin
				kind        = KIND_COMMIT;
				trace_key   = cur.commit_key;
				last_of_run = !cur.evict;
			end
			SEL_EVICT: begin
				kind      = KIND_EVICT;
				trace_key = cur.evict_key;
			end
			default: begin
				kind = KIND_STAGED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
			sel_q <= SEL_STAGED;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q  <= !rp_q;
				sel_q <= SEL_STAGED;
			end else if (adv) begin
				sel_q <= sel_q + 1'b1;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_bundle;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue count overflow");

	a_evict_sel_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sel_q == SEL_EVICT |-> cur.evict && cur.commit)
		else $error("eviction result from bundle without eviction");

	a_commit_sel_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sel_q == SEL_COMMIT |-> cur.commit)
		else $error("commit result from bundle without commit");

endmodule

// File: design/trace_context_frame_capture_unit.sv
// ----------------------------------------------------------------------------
// trace_context_frame_capture_unit
// Captures trace context frames from a byte stream.
// ----------------------------------------------------------------------------
// Message bytes enter on the in channel (valid/ready), one byte per item,
// end_of_message marking the last byte. Results leave on the out channel:
// staged path bytes, a commit with the trace id at the last path byte, and
// an eviction of the oldest ring entry when the ring wraps; last_of_run
// flags the final result of one input item.
// The frame type byte is written on the cfg channel (always ready); write it
// only while the block is idle.
// Throughput: one item per cycle. An item's results are written into the
// bundle queue as it is accepted, behind any queued results. The commit byte
// yields up to three results, drained one per cycle from a two-slot bundle
// queue; bytes that cause no results keep being accepted meanwhile.
// When out_ready is low the queue fills; in_ready then drops only for bytes
// that would emit (path bytes of an accepted frame).
// Reset clears the parser, the ring pointers and sets the frame type to
// 0x0A. Ring contents are not cleared; no entry is read before it is written.
// ----------------------------------------------------------------------------
module trace_context_frame_capture_unit #(
	parameter int RING_DEPTH = tcfc_pkg::RING_DEPTH_DEF,
	parameter int PATH_BYTES = tcfc_pkg::PATH_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [6:0]  path_index,
	output logic [7:0]  path_value,
	output logic [63:0] trace_key,
	output logic        last_of_run
);
	import tcfc_pkg::*;

	logic [7:0]   frame_type_q;
	logic         q_full;
	logic         push;
	tcfc_bundle_t push_bundle;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_type_q <= CTX_FRAME_TYPE_RST;
		end else if (cfg_valid && cfg_ready) begin
			frame_type_q <= cfg_data;
		end
	end

	tcfc_parse #(
		.RING_DEPTH(RING_DEPTH),
		.PATH_BYTES(PATH_BYTES)
	) u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctx_frame_type(frame_type_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.end_of_message(end_of_message),
		.q_full        (q_full),
		.push          (push),
		.push_bundle   (push_bundle)
	);

	tcfc_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_bundle(push_bundle),
		.q_full     (q_full),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.path_index (path_index),
		.path_value (path_value),
		.trace_key  (trace_key),
		.last_of_run(last_of_run)
	);

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for trace_context_frame_capture_unit. Message bytes go
// in on the in channel, and a local parser model predicts the staged path
// bytes, commits and evictions. Every result taken from the out channel is
// compared with the oldest prediction. Both sides idle at random outside one
// steady phase. The frame type register is rewritten between phases, and one
// phase holds the output off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb;
	import tcfc_pkg::*;

	localparam int RING_SZ   = RING_DEPTH_DEF;
	localparam int PATH_SZ   = PATH_BYTES_DEF;
	localparam int PATH_END  = PATH_FIRST + PATH_SZ - 1;
	localparam int FRAME_LEN = PATH_END + 1;

	typedef struct packed {
		logic [1:0]  kind;
		logic [6:0]  idx;
		logic [7:0]  val;
		logic [63:0] key;
		logic        last;
	} capture_out_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = 8'h00;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [6:0]  path_index;
	logic [7:0]  path_value;
	logic [63:0] trace_key;
	logic        last_of_run;

	// parser model state
	logic [7:0]  frame_type_q;
	int          pos_q;
	logic [31:0] hdr_q;
	logic        frame_ok_q;
	logic [63:0] trace_q;
	logic [63:0] ring_q [RING_SZ];
	int          head_q;
	int          tail_q;

	capture_out_t due_outputs [$];
	logic [7:0]   frame_buf [$];
	int           mismatches = 0;
	int           items_sent = 0;
	int           hold_cycles = 0;
	bit           steady = 1'b0;

	trace_context_frame_capture_unit #(
		.RING_DEPTH(RING_SZ),
		.PATH_BYTES(PATH_SZ)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.end_of_message(end_of_message),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.path_index(path_index),
		.path_value(path_value),
		.trace_key(trace_key),
		.last_of_run(last_of_run)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic capture_out_t make_out(logic [1:0] k, logic [6:0] i, logic [7:0] v,
			logic [63:0] key);
		capture_out_t r;
		r.kind = k;
		r.idx  = i;
		r.val  = v;
		r.key  = key;
		r.last = 1'b0;
		return r;
	endfunction

	task automatic predict_capture(input logic [7:0] b, input logic eom);
		capture_out_t run [$];
		bit magic;
		if (pos_q < 4) begin
			hdr_q = {hdr_q[23:0], b};
			if (pos_q == 3) begin
				magic = (hdr_q == MAGIC_HTTP) || (hdr_q == MAGIC_GET) ||
					(hdr_q == MAGIC_POST) || (hdr_q == MAGIC_PRI);
				frame_ok_q = !magic && (b == frame_type_q);
			end
		end else if (pos_q >= TRACE_FIRST && pos_q < PATH_FIRST) begin
			trace_q = {trace_q[55:0], b};
		end else if (pos_q >= PATH_FIRST && pos_q <= PATH_END && frame_ok_q) begin
			run.push_back(make_out(KIND_STAGED, 7'(pos_q - PATH_FIRST), b, 64'd0));
			if (pos_q == PATH_END) begin
				run.push_back(make_out(KIND_COMMIT, 7'd0, 8'd0, trace_q));
				ring_q[tail_q] = trace_q;
				tail_q = (tail_q + 1) % RING_SZ;
				if (head_q == tail_q) begin
					run.push_back(make_out(KIND_EVICT, 7'd0, 8'd0, ring_q[head_q]));
					head_q = (head_q + 1) % RING_SZ;
				end
			end
		end
		if (pos_q < FRAME_LEN)
			pos_q++;
		if (eom) begin
			pos_q = 0;
			hdr_q = 32'd0;
			frame_ok_q = 1'b0;
			trace_q = 64'd0;
		end
		if (run.size() > 0)
			run[run.size() - 1].last = 1'b1;
		foreach (run[i])
			due_outputs.push_back(run[i]);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic eom);
		@(negedge clk);
		if (!steady && $urandom_range(0, 99) < 13) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_message <= eom;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		predict_capture(b, eom);
	endtask

	task automatic send_frame_buf();
		foreach (frame_buf[i])
			send_byte(frame_buf[i], i == frame_buf.size() - 1);
		frame_buf.delete();
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_outputs.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_frame_type(input logic [7:0] v);
		wait_idle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		frame_type_q = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly well-formed frames with random content; some short, some
	// running past the path, some with an HTTP magic header, some noise.
	task automatic build_random_message();
		int shape;
		int len;
		logic [31:0] cands [$];
		logic [31:0] magic_w;
		bit use_magic;
		logic [7:0] b;
		shape = $urandom_range(0, 99);
		if (MAGIC_HTTP[7:0] == frame_type_q) cands.push_back(MAGIC_HTTP);
		if (MAGIC_GET[7:0] == frame_type_q) cands.push_back(MAGIC_GET);
		if (MAGIC_POST[7:0] == frame_type_q) cands.push_back(MAGIC_POST);
		if (MAGIC_PRI[7:0] == frame_type_q) cands.push_back(MAGIC_PRI);
		use_magic = (cands.size() > 0) && ($urandom_range(0, 3) == 0);
		magic_w = use_magic ? cands[$urandom_range(0, cands.size() - 1)] : 32'd0;
		if (shape < 75)
			len = FRAME_LEN + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
		else if (shape < 87)
			len = $urandom_range(1, FRAME_LEN - 1);
		else
			len = $urandom_range(1, FRAME_LEN + 3);
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom_range(0, 255));
			if (shape < 87) begin
				if (i == 3)
					b = frame_type_q;
				if (use_magic && i < 4)
					b = magic_w[31 - 8 * i -: 8];
			end
			frame_buf.push_back(b);
		end
	endtask

	task automatic test_short_messages();
		frame_buf = '{8'hFF};
		send_frame_buf();
		frame_buf = '{8'h12, 8'h34, 8'h56, CTX_FRAME_TYPE_RST};
		send_frame_buf();
	endtask

	// Accepted frame at the reset frame type, extreme bytes, two bytes past
	// the path before end of message.
	task automatic test_full_frame();
		logic [63:0] trace_id;
		trace_id = 64'hFF00_A500_5A00_C301;
		frame_buf = '{8'h00, 8'hFF, 8'h00, CTX_FRAME_TYPE_RST,
			8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
		for (int i = 0; i < 8; i++)
			frame_buf.push_back(trace_id[63 - 8 * i -: 8]);
		for (int i = 0; i < PATH_SZ; i++)
			frame_buf.push_back((i == 0) ? 8'hFF : 8'(i * 53));
		frame_buf.push_back(8'h7F);
		frame_buf.push_back(8'hFF);
		send_frame_buf();
	endtask

	task automatic test_output_backpressure();
		wait_idle();
		@(posedge clk);
		hold_cycles = 150;
		for (int i = 0; i < FRAME_LEN; i++)
			frame_buf.push_back((i == 3) ? frame_type_q : 8'($urandom_range(0, 255)));
		send_frame_buf();
	endtask

	task automatic test_random_traffic(input logic [7:0] ftype, input int count,
			input bit no_idle);
		int stop_at;
		set_frame_type(ftype);
		@(posedge clk);
		steady = no_idle;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			build_random_message();
			send_frame_buf();
		end
		wait_idle();
		@(posedge clk);
		steady = 1'b0;
	endtask

	// output side: random stalls, plus a counted hold-off on request
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 13);
		end
	end

	always @(posedge clk) begin : check_results
		capture_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (due_outputs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: kind=%0d idx=%0d val=%h key=%h last=%b",
						kind, path_index, path_value, trace_key, last_of_run);
			end else begin
				want = due_outputs.pop_front();
				if (kind !== want.kind || path_index !== want.idx ||
						path_value !== want.val || trace_key !== want.key ||
						last_of_run !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("exp/act kind %0d/%0d idx %0d/%0d val %h/%h key %h/%h last %b/%b",
							want.kind, kind, want.idx, path_index, want.val, path_value,
							want.key, trace_key, want.last, last_of_run);
				end
			end
		end
	end

	initial begin
		frame_type_q = CTX_FRAME_TYPE_RST;
		pos_q = 0;
		hdr_q = 32'd0;
		frame_ok_q = 1'b0;
		trace_q = 64'd0;
		head_q = 0;
		tail_q = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		test_short_messages();
		test_full_frame();
		test_output_backpressure();
		test_random_traffic(8'h20, 40, 1'b0);
		test_random_traffic(8'h50, 40, 1'b1);

		wait_idle();
		repeat (20) @(posedge clk);
		mismatches += due_outputs.size();
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule
